@@ src/mhpd_pkg.sv @@
`timescale 1ns / 1ps

package mhpd_pkg;

  // frame layout: id, header, seven data bytes, checksum
  localparam int FRAME_LEN = 10;
  localparam int N_DATA = 7;

  // count value at which the arriving byte is the checksum
  localparam logic [3:0] CNT_CHECKSUM = 4'(FRAME_LEN - 1);
  localparam logic [3:0] CNT_HEADER = 4'd1;
  localparam logic [3:0] CNT_FIRST_DATA = 4'd2;

  // one result item as it leaves the deframer core
  typedef struct packed {
    logic                          packet_found;
    logic [6:0]                    packet_id;
    logic [N_DATA-1:0][7:0]        data;
  } mhpd_result_t;

endpackage

@@ src/mhpd_core.sv @@
`timescale 1ns / 1ps

module mhpd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output mhpd_pkg::mhpd_result_t res
);

  logic       in_packet_r;
  logic [3:0] count_r;
  logic [7:0] sum_r;
  logic [6:0] id_r;
  logic [7:0] header_r;
  logic [6:0] data_r [mhpd_pkg::N_DATA];

  logic       is_payload;
  logic       last_byte;
  logic [3:0] data_idx;

  assign is_payload = rx_byte[7];
  assign last_byte  = in_packet_r && is_payload && (count_r == mhpd_pkg::CNT_CHECKSUM);
  assign data_idx   = count_r - mhpd_pkg::CNT_FIRST_DATA;

  // result of this byte: rebuild data bytes and check the running sum
  always_comb begin
    res = '0;
    if (last_byte && (sum_r[6:0] == rx_byte[6:0])) begin
      res.packet_found = 1'b1;
      res.packet_id    = id_r;
      for (int k = 0; k < mhpd_pkg::N_DATA; k++) begin
        res.data[k] = {header_r[k], data_r[k]};
      end
    end
  end

  // frame control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      count_r     <= '0;
    end else if (accept) begin
      if (in_packet_r) begin
        if (!is_payload || last_byte) begin
          in_packet_r <= 1'b0;
        end else begin
          count_r <= count_r + 4'd1;
        end
      end else if (!is_payload) begin
        in_packet_r <= 1'b1;
        count_r     <= 4'd1;
      end
    end
  end

  // stored frame bytes and running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_packet_r) begin
        if (is_payload && !last_byte) begin
          sum_r <= sum_r + rx_byte;
          if (count_r == mhpd_pkg::CNT_HEADER) begin
            header_r <= rx_byte;
          end else begin
            data_r[data_idx[2:0]] <= rx_byte[6:0];
          end
        end
      end else if (!is_payload) begin
        id_r  <= rx_byte[6:0];
        sum_r <= {1'b0, rx_byte[6:0]};
      end
    end
  end

endmodule

@@ src/msb_header_packet_deframer.sv @@
`timescale 1ns / 1ps

// Deframer for 10-byte packets: id (bit 7 clear), header carrying bit 7 of
// the seven data bytes, seven data bytes with bit 7 set, then a checksum.
// Input channel: one received byte per item on in_rx_byte, taken when
// in_valid is high and in_stall is low.
// Result channel: one result item per input item, registered, shown in the
// cycle after the byte is taken. out_packet_found is 1 only on the item of
// a checksum byte that closes a good packet; then out_packet_id and
// out_data_byte_0..6 carry the packet, otherwise all fields are zero.
// Throughput is one byte per cycle unless a result stalls: the running sum
// and the decode sit between the input port and the single output register.
// When the receiver holds out_stall with a result pending, in_stall rises
// in the same cycle, so no item is lost; the pending result holds.
// Synchronous reset clears the frame state (waiting for an id) and empties
// the output register.

module msb_header_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_packet_found,
  output logic [6:0] out_packet_id,
  output logic [7:0] out_data_byte_0,
  output logic [7:0] out_data_byte_1,
  output logic [7:0] out_data_byte_2,
  output logic [7:0] out_data_byte_3,
  output logic [7:0] out_data_byte_4,
  output logic [7:0] out_data_byte_5,
  output logic [7:0] out_data_byte_6
);

  logic                  accept;
  logic                  out_valid_r;
  mhpd_pkg::mhpd_result_t res_nxt;
  mhpd_pkg::mhpd_result_t res_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  mhpd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .res     (res_nxt)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packet_found = res_r.packet_found;
  assign out_packet_id    = res_r.packet_id;
  assign out_data_byte_0  = res_r.data[0];
  assign out_data_byte_1  = res_r.data[1];
  assign out_data_byte_2  = res_r.data[2];
  assign out_data_byte_3  = res_r.data[3];
  assign out_data_byte_4  = res_r.data[4];
  assign out_data_byte_5  = res_r.data[5];
  assign out_data_byte_6  = res_r.data[6];

endmodule

@@ src/mhpd_checker.sv @@
`timescale 1ns / 1ps

module mhpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_packet_found,
  input logic [6:0] out_packet_id,
  input logic [7:0] out_data_byte_0,
  input logic [7:0] out_data_byte_1,
  input logic [7:0] out_data_byte_2,
  input logic [7:0] out_data_byte_3,
  input logic [7:0] out_data_byte_4,
  input logic [7:0] out_data_byte_5,
  input logic [7:0] out_data_byte_6
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // every taken item gives a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after item taken");

  // input is held back only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without pending result");

  // no packet means all fields zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_found |->
      out_packet_id == 7'd0 && out_data_byte_0 == 8'd0 && out_data_byte_1 == 8'd0 &&
      out_data_byte_2 == 8'd0 && out_data_byte_3 == 8'd0 && out_data_byte_4 == 8'd0 &&
      out_data_byte_5 == 8'd0 && out_data_byte_6 == 8'd0)
    else $error("fields not zero without packet");

  // a fresh packet result comes from a checksum byte with bit 7 set
  a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall) && out_packet_found && out_valid |->
      $past(in_rx_byte[7]))
    else $error("packet closed by id-class byte");

endmodule

bind msb_header_packet_deframer mhpd_checker u_mhpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_packet_found (out_packet_found),
  .out_packet_id    (out_packet_id),
  .out_data_byte_0  (out_data_byte_0),
  .out_data_byte_1  (out_data_byte_1),
  .out_data_byte_2  (out_data_byte_2),
  .out_data_byte_3  (out_data_byte_3),
  .out_data_byte_4  (out_data_byte_4),
  .out_data_byte_5  (out_data_byte_5),
  .out_data_byte_6  (out_data_byte_6)
);
